### sv/image_upscale_2x_interpolate_macros.svh
// Assertion macros for the 2x image upscaler
`ifndef IMAGE_UPSCALE_2X_INTERPOLATE_MACROS_SVH
`define IMAGE_UPSCALE_2X_INTERPOLATE_MACROS_SVH

// same-cycle implication, disabled in reset
`define IU2X_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define IU2X_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/iu2x_pkg.sv
// Shared types, constants and pixel arithmetic for the 2x image upscaler
package iu2x_pkg;

  localparam int unsigned MaxWidth  = 2048;
  localparam int unsigned MaxHeight = 2048;
  localparam int unsigned ColW      = $clog2(MaxWidth);
  localparam int unsigned RowW      = $clog2(MaxHeight);
  localparam int unsigned DimW      = 12;
  localparam int unsigned CoordW    = 12;
  localparam int unsigned ChanW     = 8;
  localparam int unsigned PixW      = 3 * ChanW;

  localparam logic [0:0] RegImageWidth  = 1'b0;
  localparam logic [0:0] RegImageHeight = 1'b1;

  // result slots of one source pixel, in output order
  localparam logic [1:0] SelDiag   = 2'd0;
  localparam logic [1:0] SelUp     = 2'd1;
  localparam logic [1:0] SelLeft   = 2'd2;
  localparam logic [1:0] SelCentre = 2'd3;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pix_t;

  typedef struct packed {
    pix_t            cur;
    pix_t            left;
    pix_t            upleft;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            img_end;
  } item_t;

  typedef struct packed {
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    pix_t              pix;
    logic              last;
  } res_t;

  function automatic pix_t pix_mean(pix_t a, pix_t b);
    logic [ChanW:0] sr;
    logic [ChanW:0] sg;
    logic [ChanW:0] sb;
    pix_t           m;
    sr = {1'b0, a.red} + {1'b0, b.red};
    sg = {1'b0, a.green} + {1'b0, b.green};
    sb = {1'b0, a.blue} + {1'b0, b.blue};
    m.red   = sr[ChanW:1];
    m.green = sg[ChanW:1];
    m.blue  = sb[ChanW:1];
    return m;
  endfunction

  function automatic logic [DimW-1:0] clamp_dim(logic [DimW-1:0] v, logic [DimW-1:0] hi);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

### sv/iu2x_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data
module iu2x_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/iu2x_interp.sv
// Interpolation datapath: builds one tagged result pixel of a held source pixel
module iu2x_interp (
  input  iu2x_pkg::item_t item_i,
  input  iu2x_pkg::pix_t  up_i,
  input  logic [1:0]      sel_i,
  output iu2x_pkg::res_t  res_o
);

  iu2x_pkg::pix_t                hmean;
  iu2x_pkg::pix_t                hup;
  iu2x_pkg::pix_t                diag;
  iu2x_pkg::pix_t                vmean;
  logic [iu2x_pkg::CoordW-1:0]   row2;
  logic [iu2x_pkg::CoordW-1:0]   col2;

  assign hmean = iu2x_pkg::pix_mean(item_i.left, item_i.cur);
  assign hup   = iu2x_pkg::pix_mean(item_i.upleft, up_i);
  assign diag  = iu2x_pkg::pix_mean(hup, hmean);
  assign vmean = iu2x_pkg::pix_mean(up_i, item_i.cur);
  assign row2  = {item_i.row, 1'b0};
  assign col2  = {item_i.col, 1'b0};

  always_comb begin
    res_o.row  = row2;
    res_o.col  = col2;
    res_o.pix  = item_i.cur;
    res_o.last = 1'b0;
    case (sel_i)
      iu2x_pkg::SelDiag: begin
        res_o.row = row2 - iu2x_pkg::CoordW'(1);
        res_o.col = col2 - iu2x_pkg::CoordW'(1);
        res_o.pix = diag;
      end
      iu2x_pkg::SelUp: begin
        res_o.row = row2 - iu2x_pkg::CoordW'(1);
        res_o.pix = vmean;
      end
      iu2x_pkg::SelLeft: begin
        res_o.col = col2 - iu2x_pkg::CoordW'(1);
        res_o.pix = hmean;
      end
      iu2x_pkg::SelCentre: begin
        res_o.last = item_i.img_end;
      end
      default: begin
        res_o.last = 1'b0;
      end
    endcase
  end

endmodule

### sv/image_upscale_2x_interpolate.sv
// Top level of the 2x bilinear image upscaler
// Source pixels arrive in raster order; each yields one to four pixels of the
// (2H-1)x(2W-1) enlarged image, tagged with row and column.
// A source pixel occupies the block until all of its results are produced: the
// single output register moves one pixel per cycle while out_stall_i is low, and
// the next source pixel is taken in the cycle the last result of the current one
// is loaded. The previous source row is kept in a 2048 x 24 RAM; it needs no
// clearing, since a row is only read after it is written. last marks the final
// pixel of each image.
`include "image_upscale_2x_interpolate_macros.svh"

module image_upscale_2x_interpolate (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [0:0]                    cfg_idx_i,
  input  logic [iu2x_pkg::DimW-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [iu2x_pkg::ChanW-1:0]    in_red_i,
  input  logic [iu2x_pkg::ChanW-1:0]    in_green_i,
  input  logic [iu2x_pkg::ChanW-1:0]    in_blue_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [iu2x_pkg::CoordW-1:0]   out_row_o,
  output logic [iu2x_pkg::CoordW-1:0]   out_col_o,
  output logic [iu2x_pkg::ChanW-1:0]    out_red_o,
  output logic [iu2x_pkg::ChanW-1:0]    out_green_o,
  output logic [iu2x_pkg::ChanW-1:0]    out_blue_o,
  output logic                          last_o
);

  logic [iu2x_pkg::DimW-1:0] width_q, height_q;
  logic [iu2x_pkg::DimW-1:0] w_eff, h_eff;
  logic [iu2x_pkg::ColW-1:0] col_count_q, col_count_d;
  logic [iu2x_pkg::RowW-1:0] row_count_q, row_count_d;
  iu2x_pkg::pix_t            left_pixel_q;
  iu2x_pkg::pix_t            cur;
  iu2x_pkg::pix_t            up;
  logic                      row_end, img_end;

  iu2x_pkg::item_t           item_q;
  logic                      b_valid_q, b_valid_d;
  logic [3:0]                rem_q, rem_d, rem_init, sel_1h;
  logic [1:0]                sel;
  iu2x_pkg::res_t            res;
  iu2x_pkg::res_t            out_q;
  logic                      out_valid_q, out_valid_d;

  logic                      in_xfer, o_load, b_done;

  assign in_xfer = in_valid_i && !in_stall_o;
  assign o_load  = b_valid_q && (!out_valid_q || !out_stall_i);
  assign b_done  = o_load && (rem_q[2:0] == 3'b000);
  assign in_stall_o = b_valid_q && !b_done;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= iu2x_pkg::DimW'(640);
      height_q <= iu2x_pkg::DimW'(480);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        iu2x_pkg::RegImageWidth:  width_q  <= cfg_wdata_i;
        iu2x_pkg::RegImageHeight: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign w_eff = iu2x_pkg::clamp_dim(width_q, iu2x_pkg::DimW'(iu2x_pkg::MaxWidth));
  assign h_eff = iu2x_pkg::clamp_dim(height_q, iu2x_pkg::DimW'(iu2x_pkg::MaxHeight));

  assign cur.red   = in_red_i;
  assign cur.green = in_green_i;
  assign cur.blue  = in_blue_i;

  assign row_end = ({1'b0, col_count_q} + iu2x_pkg::DimW'(1)) >= w_eff;
  assign img_end = row_end && (({1'b0, row_count_q} + iu2x_pkg::DimW'(1)) >= h_eff);

  always_comb begin
    col_count_d = col_count_q;
    row_count_d = row_count_q;
    if (in_xfer) begin
      if (row_end) begin
        col_count_d = '0;
        row_count_d = img_end ? '0 : row_count_q + iu2x_pkg::RowW'(1);
      end else begin
        col_count_d = col_count_q + iu2x_pkg::ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_count_q  <= '0;
      row_count_q  <= '0;
      left_pixel_q <= '0;
    end else begin
      col_count_q <= col_count_d;
      row_count_q <= row_count_d;
      if (in_xfer) begin
        left_pixel_q <= cur;
      end
    end
  end

  // previous source row; read-first, so the same column reads last row's pixel
  iu2x_ram #(
    .WIDTH (iu2x_pkg::PixW),
    .DEPTH (iu2x_pkg::MaxWidth)
  ) u_row_store (
    .clk_i   (clk_i),
    .we_i    (in_xfer),
    .waddr_i (col_count_q),
    .wdata_i (cur),
    .re_i    (in_xfer),
    .raddr_i (col_count_q),
    .rdata_o (up)
  );

  assign rem_init = {1'b1,
                     (col_count_q != '0),
                     (row_count_q != '0),
                     (row_count_q != '0) && (col_count_q != '0)};

  always_comb begin
    if (rem_q[0]) begin
      sel = iu2x_pkg::SelDiag;
    end else if (rem_q[1]) begin
      sel = iu2x_pkg::SelUp;
    end else if (rem_q[2]) begin
      sel = iu2x_pkg::SelLeft;
    end else begin
      sel = iu2x_pkg::SelCentre;
    end
    sel_1h = 4'b0001 << sel;
  end

  always_comb begin
    b_valid_d = b_valid_q;
    rem_d     = rem_q;
    if (in_xfer) begin
      b_valid_d = 1'b1;
      rem_d     = rem_init;
    end else if (o_load) begin
      b_valid_d = !b_done;
      rem_d     = rem_q & ~sel_1h;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      rem_q     <= '0;
    end else begin
      b_valid_q <= b_valid_d;
      rem_q     <= rem_d;
    end
  end

  // held pixel; upleft is the read data of the previous transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.cur     <= cur;
      item_q.left    <= left_pixel_q;
      item_q.upleft  <= up;
      item_q.row     <= row_count_q;
      item_q.col     <= col_count_q;
      item_q.img_end <= img_end;
    end
  end

  iu2x_interp u_interp (
    .item_i (item_q),
    .up_i   (up),
    .sel_i  (sel),
    .res_o  (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (o_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_q.row;
  assign out_col_o   = out_q.col;
  assign out_red_o   = out_q.pix.red;
  assign out_green_o = out_q.pix.green;
  assign out_blue_o  = out_q.pix.blue;
  assign last_o      = out_q.last;

  `IU2X_ASSERT_IMP(a_centre_pending, b_valid_q, rem_q[3], "centre result lost from held pixel")
  `IU2X_ASSERT_NXT(a_xfer_holds, in_xfer, b_valid_q && rem_q[3], "transfer did not load held pixel")
  `IU2X_ASSERT_IMP(a_last_even, out_valid_o && last_o, !out_row_o[0] && !out_col_o[0],
                   "last on an interpolated position")
  `IU2X_ASSERT_IMP(a_col_range, 1'b1, {item_q.col, 1'b0} <= iu2x_pkg::DimW'(4094) ||
                   !b_valid_q, "held column out of range")

endmodule
